>>> rtl/dns_name_label_encoder_top_defines.svh
// Assertion macros used by the encoder back end.
// Define ASSERT_OFF to compile the checks away.
`ifndef DNS_NAME_LABEL_ENCODER_TOP_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition implies consequence in the same cycle.
`define DNLE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define DNLE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DNLE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DNLE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/dnle_pkg.sv
`default_nettype none

package dnle_pkg;

    // Longest label kept; further characters are dropped
    localparam int MAX_LABEL   = 62;
    localparam int LABEL_DEPTH = 62;
    localparam int CNT_W       = 6;

    // Label separator character
    localparam logic [7:0] SEP_CHAR = 8'h2E;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Command codes produced by the front end
    localparam logic [1:0] CMD_CHAR = 2'd0;
    localparam logic [1:0] CMD_SEP  = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    typedef struct packed {
        logic [1:0] code;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/dnle_front.sv
`default_nettype none

module dnle_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_action,
    input  wire logic [7:0]    s_name_char,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output dnle_pkg::cmd_t     cmd
);

    logic           valid_reg;
    logic           valid_next;
    dnle_pkg::cmd_t cmd_reg;
    dnle_pkg::cmd_t cmd_next;

    // Accept when the holding stage is empty or draining this cycle
    assign s_ready   = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // Classify the incoming item
    always_comb begin
        cmd_next = cmd_reg;
        if (s_valid && s_ready) begin
            cmd_next.data = s_name_char;
            if (s_action) begin
                cmd_next.code = dnle_pkg::CMD_END;
            end else if (s_name_char == dnle_pkg::SEP_CHAR) begin
                cmd_next.code = dnle_pkg::CMD_SEP;
            end else begin
                cmd_next.code = dnle_pkg::CMD_CHAR;
            end
        end
    end

    // Hold the classified item until the queue takes it
    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

>>> rtl/dnle_cmd_queue.sv
`default_nettype none

module dnle_cmd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dnle_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dnle_pkg::cmd_t     out_cmd
);

    dnle_pkg::cmd_t                    entry_reg [dnle_pkg::QUEUE_DEPTH];
    logic [dnle_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [dnle_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [dnle_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [dnle_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [dnle_pkg::QCNT_W-1:0]       fill_reg;
    logic [dnle_pkg::QCNT_W-1:0]       fill_next;
    logic                              push;
    logic                              pop;

    assign in_ready  = fill_reg != dnle_pkg::QCNT_W'(dnle_pkg::QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dnle_back.sv
`default_nettype none

`include "dns_name_label_encoder_top_defines.svh"

module dnle_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire dnle_pkg::cmd_t cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_name_done,
    output logic               m_label_overflow
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_TERM = 3'd4;

    localparam int CW = dnle_pkg::CNT_W;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          end_reg;
    logic          end_next;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic [7:0]    out_byte_reg;
    logic          done_reg;
    logic          out_ovf_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    label_mem [dnle_pkg::LABEL_DEPTH];

    logic          slot_free;
    logic          mem_we;
    logic          load;
    logic [7:0]    load_byte;
    logic          load_done;

    assign slot_free        = !m_valid_reg || m_ready;
    assign cmd_ready        = state_reg == ST_IDLE;
    assign m_valid          = m_valid_reg;
    assign m_out_byte       = out_byte_reg;
    assign m_name_done      = done_reg;
    assign m_label_overflow = out_ovf_reg;

    // Sequence: store characters, then flush length, bytes and, at end of name, terminator
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        end_next   = end_reg;
        mem_we     = 1'b0;
        load       = 1'b0;
        load_byte  = 8'h00;
        load_done  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.code)
                        dnle_pkg::CMD_CHAR: begin
                            if (count_reg < CW'(dnle_pkg::MAX_LABEL)) begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        dnle_pkg::CMD_SEP: begin
                            end_next   = 1'b0;
                            state_next = ST_LEN;
                        end
                        dnle_pkg::CMD_END: begin
                            end_next   = 1'b1;
                            state_next = ST_LEN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LEN: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_byte = 8'(count_reg);
                    idx_next  = '0;
                    if (count_reg == '0) begin
                        state_next = end_reg ? ST_TERM : ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // wait for the registered memory read
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_byte = rd_data_reg;
                    if (idx_reg == count_reg - 1'b1) begin
                        count_next = '0;
                        state_next = end_reg ? ST_TERM : ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_TERM: begin
                if (slot_free) begin
                    load       = 1'b1;
                    load_done  = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a new item or drop the taken one
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            ovf_reg     <= 1'b0;
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            ovf_reg     <= ovf_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg <= load_byte;
            done_reg     <= load_done;
            out_ovf_reg  <= ovf_reg;
        end
    end

    // Label buffer: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            label_mem[count_reg] <= cmd.data;
        end
        rd_data_reg <= label_mem[idx_reg];
    end

    `DNLE_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1,
        count_reg <= CW'(dnle_pkg::MAX_LABEL), "label count above limit")
    `DNLE_ASSERT_IMP(a_done_zero, aclk, aresetn, m_valid_reg && done_reg,
        out_byte_reg == 8'h00, "terminator byte not zero")
    `DNLE_ASSERT_IMP(a_idx_range, aclk, aresetn,
        state_reg == ST_READ || state_reg == ST_DATA,
        idx_reg < count_reg, "flush index past label end")
    `DNLE_ASSERT_NXT(a_ovf_clear, aclk, aresetn, state_reg == ST_TERM && slot_free,
        !ovf_reg && state_reg == ST_IDLE, "overflow not cleared after terminator")

endmodule

`default_nettype wire

>>> rtl/dns_name_label_encoder_top.sv
// Channel   Direction  Ports                                        Handshake
// --------  ---------  -------------------------------------------  ---------------
// s_        in         s_action, s_name_char                        s_valid/s_ready
// m_        out        m_out_byte, m_name_done, m_label_overflow     m_valid/m_ready
//
// A character taken passes through the front register and then the two-entry
// command queue before it is written to the label buffer. On a separator or end
// of name the back end flushes the held bytes: the length byte, then a registered
// read and an output load per byte; end of name adds the zero terminator. Reset
// (aresetn low, synchronous) empties the queue and output register; output
// stalls back up to the front until full.
`default_nettype none

module dns_name_label_encoder_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_action,
    input  wire logic [7:0] s_name_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_name_done,
    output logic            m_label_overflow
);

    logic           fr_valid;
    logic           fr_ready;
    dnle_pkg::cmd_t fr_cmd;
    logic           q_valid;
    logic           q_ready;
    dnle_pkg::cmd_t q_cmd;

    dnle_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_name_char (s_name_char),
        .cmd_valid   (fr_valid),
        .cmd_ready   (fr_ready),
        .cmd         (fr_cmd)
    );

    dnle_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cmd    (fr_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    dnle_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (q_valid),
        .cmd_ready        (q_ready),
        .cmd              (q_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_name_done      (m_name_done),
        .m_label_overflow (m_label_overflow)
    );

endmodule

`default_nettype wire

>>> verif/dns_name_label_encoder_top_test.sv
module dns_name_label_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;
    localparam int   LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic       act;
        logic [7:0] ch;
    } name_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       name_done;
        logic       label_overflow;
    } wire_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_action = 1'b0;
    logic [7:0] s_name_char = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_name_done;
    logic       m_label_overflow;

    // Stimulus and expected wire bytes
    name_item_t name_items_pending[$];
    wire_byte_t wire_bytes_due[$];

    // Predicted encoder state
    logic [7:0] held_label [dnle_pkg::LABEL_DEPTH];
    int         held_len = 0;
    logic       drop_flag = 1'b0;

    // Handshake bookkeeping
    logic s_taken = 1'b0;
    int   tx_gap = 0;
    int   rx_hold_cnt = 0;
    int   rx_hold_ask = 0;
    int   rx_hold_seen = 0;
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;

    int items_queued = 0;
    int items_taken = 0;
    int bytes_seen = 0;
    int names_seen = 0;
    int overflow_bytes_seen = 0;
    int error_count = 0;

    dns_name_label_encoder_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_name_char      (s_name_char),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_name_done      (m_name_done),
        .m_label_overflow (m_label_overflow)
    );

    always #10 aclk = ~aclk;

    task automatic report_error(input string what, input int unsigned got,
                                input int unsigned want);
        error_count++;
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic emit_wire_byte(input logic [7:0] b, input logic done);
        wire_byte_t w;
        w.out_byte       = b;
        w.name_done      = done;
        w.label_overflow = drop_flag;
        wire_bytes_due.push_back(w);
    endtask

    // Predict the wire bytes caused by one accepted item
    task automatic encode_name_byte(input logic act, input logic [7:0] ch);
        if (act == ACT_END || ch == dnle_pkg::SEP_CHAR) begin
            emit_wire_byte(8'(held_len), 1'b0);
            for (int i = 0; i < held_len; i++)
                emit_wire_byte(held_label[i], 1'b0);
            held_len = 0;
            if (act == ACT_END) begin
                emit_wire_byte(8'h00, 1'b1);
                drop_flag = 1'b0;
            end
        end else if (held_len < dnle_pkg::MAX_LABEL) begin
            held_label[held_len] = ch;
            held_len++;
        end else begin
            drop_flag = 1'b1;
        end
    endtask

    task automatic push_item(input logic act, input logic [7:0] ch);
        name_item_t it;
        it.act = act;
        it.ch  = ch;
        name_items_pending.push_back(it);
        items_queued++;
    endtask

    function automatic logic [7:0] label_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == dnle_pkg::SEP_CHAR)
            c = 8'h2D;
        return c;
    endfunction

    // Queue one name: mostly well formed, sometimes raw noise
    task automatic queue_random_name();
        int n_labels;
        int len;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
                push_item($urandom_range(0, 3) == 0 ? ACT_END : ACT_CHAR,
                          $urandom_range(0, 3) == 0 ? dnle_pkg::SEP_CHAR
                                                    : 8'($urandom_range(0, 255)));
        end else begin
            n_labels = $urandom_range(1, 4);
            if ($urandom_range(0, 15) == 0)
                push_item(ACT_CHAR, dnle_pkg::SEP_CHAR);
            for (int l = 0; l < n_labels; l++) begin
                if ($urandom_range(0, 11) == 0)
                    len = $urandom_range(58, 66);
                else
                    len = $urandom_range(0, 8);
                repeat (len)
                    push_item(ACT_CHAR, label_char());
                if (l < n_labels - 1 || $urandom_range(0, 9) == 0)
                    push_item(ACT_CHAR, dnle_pkg::SEP_CHAR);
            end
            push_item(ACT_END, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        wait (items_taken == items_queued && wire_bytes_due.size() == 0);
    endtask

    // Sender: offer items from the pending queue, with random idle bursts
    always @(negedge aclk) begin
        name_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (tx_gap > 0) begin
                tx_gap  <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (tx_idle_on && $urandom_range(0, 5) == 0) begin
                tx_gap  <= $urandom_range(0, 9);
                s_valid <= 1'b0;
            end else if (name_items_pending.size() > 0) begin
                it = name_items_pending.pop_front();
                s_valid     <= 1'b1;
                s_action    <= it.act;
                s_name_char <= it.ch;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_seen != rx_hold_ask) begin
            rx_hold_seen <= rx_hold_ask;
            rx_hold_cnt  <= LONG_HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (rx_hold_cnt > 0) begin
            rx_hold_cnt <= rx_hold_cnt - 1;
            m_ready     <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_hold_cnt <= $urandom_range(0, 9);
            m_ready     <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check each wire byte against the oldest prediction, then predict new items
    always @(posedge aclk) begin
        wire_byte_t want;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                bytes_seen++;
                if (m_name_done)
                    names_seen++;
                if (m_label_overflow)
                    overflow_bytes_seen++;
                if (wire_bytes_due.size() == 0) begin
                    report_error("unexpected wire byte", m_out_byte, 0);
                end else begin
                    want = wire_bytes_due.pop_front();
                    if (m_out_byte !== want.out_byte)
                        report_error("out_byte", m_out_byte, want.out_byte);
                    if (m_name_done !== want.name_done)
                        report_error("name_done", m_name_done, want.name_done);
                    if (m_label_overflow !== want.label_overflow)
                        report_error("label_overflow", m_label_overflow, want.label_overflow);
                end
            end
            if (s_valid && s_ready) begin
                encode_name_byte(s_action, s_name_char);
                items_taken++;
            end
        end
    end

    // Stimulus sequence
    initial begin
        int random_items;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty name, lone dot, byte extremes, consecutive and trailing dots
        push_item(ACT_END, 8'h00);
        push_item(ACT_CHAR, dnle_pkg::SEP_CHAR);
        push_item(ACT_END, 8'hFF);
        push_item(ACT_CHAR, 8'h00);
        push_item(ACT_CHAR, 8'hFF);
        push_item(ACT_CHAR, 8'h2D);
        push_item(ACT_CHAR, 8'h2F);
        push_item(ACT_CHAR, dnle_pkg::SEP_CHAR);
        push_item(ACT_CHAR, dnle_pkg::SEP_CHAR);
        push_item(ACT_CHAR, 8'h7F);
        push_item(ACT_CHAR, 8'h80);
        push_item(ACT_END, 8'hAA);
        push_item(ACT_CHAR, 8'h41);
        push_item(ACT_CHAR, dnle_pkg::SEP_CHAR);
        push_item(ACT_END, 8'h55);
        wait_drained();

        // Overlong label while the receiver holds off: fill up and stall the input
        tx_idle_on = 1'b0;
        rx_hold_ask++;
        repeat (70)
            push_item(ACT_CHAR, label_char());
        push_item(ACT_CHAR, dnle_pkg::SEP_CHAR);
        repeat (5)
            push_item(ACT_CHAR, label_char());
        push_item(ACT_END, 8'h00);
        wait_drained();

        // Random names, idling switched on and off between names
        random_items = items_queued;
        while (items_queued - random_items < 120) begin
            wait (name_items_pending.size() == 0);
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            queue_random_name();
        end

        // Last stretch with no idling
        wait (name_items_pending.size() == 0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (items_queued - random_items < 160)
            queue_random_name();

        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Encoded %0d input items into %0d wire bytes over %0d names,",
                 items_taken, bytes_seen, names_seen);
        $display("%0d bytes carried the overflow flag; one long receiver hold-off applied.",
                 overflow_bytes_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Timeout: %0d of %0d items taken, %0d wire bytes outstanding",
                 items_taken, items_queued, wire_bytes_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
